### hdl/dgcc_pkg.sv
package dgcc_pkg;

    localparam int VERT_W = 4;
    localparam int NUMV_W = 5;
    localparam logic [NUMV_W-1:0] NUMV_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_FETCH,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic edge_rd;
        logic edge_wr;
        logic chk_init;
        logic fetch;
        logic advance;
        logic pop;
        logic pop_load;
        logic next_start;
        logic res_set;
        logic res_val;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic is_check;
        logic edge_ok;
        logic n_zero;
        logic cand_any;
        logic hit;
        logic depth_one;
        logic last_start;
        logic out_free;
    } t_status;

endpackage

### hdl/dgcc_ram.sv
module dgcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/dgcc_ctrl.sv
module dgcc_ctrl import dgcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid) begin
                    if (i_status.is_check) begin
                        n_state = i_status.n_zero ? ST_DONE : ST_FETCH;
                    end else if (i_status.edge_ok) begin
                        n_state = ST_EDGE_WR;
                    end
                end
            end
            ST_EDGE_WR: n_state = ST_IDLE;
            ST_FETCH:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_status.cand_any) begin
                    n_state = i_status.hit ? ST_DONE : ST_FETCH;
                end else if (i_status.depth_one) begin
                    n_state = i_status.last_start ? ST_DONE : ST_FETCH;
                end else begin
                    n_state = ST_POP;
                end
            end
            ST_POP:     n_state = ST_SCAN;
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    if (i_status.is_check) begin
                        if (i_status.n_zero) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_val = 1'b0;
                        end else begin
                            o_cmd.chk_init = 1'b1;
                        end
                    end else if (i_status.edge_ok) begin
                        o_cmd.edge_rd = 1'b1;
                    end
                end
            end
            ST_EDGE_WR: o_cmd.edge_wr = 1'b1;
            ST_FETCH:   o_cmd.fetch = 1'b1;
            ST_SCAN: begin
                if (i_status.cand_any) begin
                    if (i_status.hit) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_val = 1'b1;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else if (i_status.depth_one) begin
                    if (i_status.last_start) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_val = 1'b0;
                    end else begin
                        o_cmd.next_start = 1'b1;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            ST_POP:     o_cmd.pop_load = 1'b1;
            ST_DONE:    o_cmd.out_load = i_status.out_free;
            default:    o_cmd = '0;
        endcase
    end

    // a search step only follows a fetch or a pop reload
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ($past(r_state) == ST_FETCH || $past(r_state) == ST_POP))
        else $error("scan entered without a row read");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_status.out_free) |=> (r_state == ST_DONE))
        else $error("done left while output slot busy");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.in_ready |-> !(o_cmd.fetch || o_cmd.pop || o_cmd.out_load))
        else $error("input ready during a search");

endmodule

### hdl/dgcc_dpath.sv
module dgcc_dpath import dgcc_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [NUMV_W-1:0] i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_req_type,
    input  logic [VERT_W-1:0] i_src,
    input  logic [VERT_W-1:0] i_dst,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic              o_has_cycle,
    input  t_cmd              i_cmd,
    output t_status           o_status
);

    localparam int N  = MAX_VERTICES;
    localparam int VW = $clog2(N);
    localparam int DW = $clog2(N + 1);

    logic [NUMV_W-1:0] r_num_vertices;
    logic [N-1:0]      r_row_vld;
    logic              r_rd_vld;
    logic [N-1:0]      r_visited,  n_visited;
    logic [N-1:0]      r_on_path,  n_on_path;
    logic [DW-1:0]     r_depth,    n_depth;
    logic [VW-1:0]     r_cur,      n_cur;
    logic [VW-1:0]     r_start,    n_start;
    logic [VW-1:0]     r_edge_src;
    logic [VW-1:0]     r_edge_dst;
    logic              r_res;
    logic              r_out_valid;
    logic              r_out_data;

    logic [DW-1:0]     eff;
    logic [N-1:0]      valid;
    logic [N-1:0]      cur_bit;
    logic [N-1:0]      row;
    logic [N-1:0]      cand;
    logic [VW-1:0]     w;
    logic [VW-1:0]     adj_raddr;
    logic [N-1:0]      adj_rdata;
    logic [N-1:0]      adj_wdata;
    logic [VW-1:0]     stk_raddr;
    logic [VW-1:0]     stk_rdata;

    function automatic logic [VW-1:0] lowest_set(input logic [N-1:0] x);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    // effective vertex count, saturated to the storage size
    always_comb begin
        if (32'(r_num_vertices) > N) begin
            eff = DW'(N);
        end else begin
            eff = DW'(r_num_vertices);
        end
        for (int i = 0; i < N; i++) begin
            valid[i] = (32'(i) < 32'(eff));
        end
    end

    assign cur_bit   = N'(1) << r_cur;
    assign row       = r_rd_vld ? (adj_rdata & valid) : '0;
    assign cand      = row & (r_on_path | ~r_visited);
    assign w         = lowest_set(cand);
    assign adj_wdata = (r_rd_vld ? adj_rdata : '0) | (N'(1) << r_edge_dst);
    assign stk_raddr = VW'(r_depth - DW'(2));

    always_comb begin
        if (i_cmd.edge_rd) begin
            adj_raddr = VW'(i_src);
        end else if (i_cmd.pop_load) begin
            adj_raddr = stk_rdata;
        end else begin
            adj_raddr = r_cur;
        end
    end

    dgcc_ram #(
        .WIDTH (N),
        .DEPTH (N)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.edge_wr),
        .i_waddr (r_edge_src),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    dgcc_ram #(
        .WIDTH (VW),
        .DEPTH (N)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fetch),
        .i_waddr (r_depth[VW-1:0]),
        .i_wdata (r_cur),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // search state next values
    always_comb begin
        n_visited = r_visited;
        n_on_path = r_on_path;
        n_depth   = r_depth;
        n_cur     = r_cur;
        n_start   = r_start;
        if (i_cmd.chk_init) begin
            n_visited = '0;
            n_on_path = '0;
            n_depth   = '0;
            n_cur     = '0;
            n_start   = '0;
        end else if (i_cmd.next_start) begin
            n_visited = '0;
            n_on_path = '0;
            n_depth   = '0;
            n_cur     = r_start + VW'(1);
            n_start   = r_start + VW'(1);
        end else if (i_cmd.fetch) begin
            n_visited = r_visited | cur_bit;
            n_on_path = r_on_path | cur_bit;
            n_depth   = r_depth + DW'(1);
        end else if (i_cmd.advance) begin
            n_cur     = w;
        end else if (i_cmd.pop) begin
            n_depth   = r_depth - DW'(1);
            n_on_path = r_on_path & ~cur_bit;
        end else if (i_cmd.pop_load) begin
            n_cur     = stk_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= NUMV_RESET;
            r_row_vld      <= '0;
            r_visited      <= '0;
            r_on_path      <= '0;
            r_depth        <= '0;
            r_cur          <= '0;
            r_start        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_vertices <= i_cfg_wdata;
            end
            if (i_cmd.edge_wr) begin
                r_row_vld[r_edge_src] <= 1'b1;
            end
            r_visited <= n_visited;
            r_on_path <= n_on_path;
            r_depth   <= n_depth;
            r_cur     <= n_cur;
            r_start   <= n_start;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[adj_raddr];
        if (i_cmd.edge_rd) begin
            r_edge_src <= VW'(i_src);
            r_edge_dst <= VW'(i_dst);
        end
        if (i_cmd.res_set) begin
            r_res <= i_cmd.res_val;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_status.in_valid   = i_s_tvalid;
    assign o_status.is_check   = i_req_type;
    assign o_status.edge_ok    = (32'(i_src) < 32'(eff)) && (32'(i_dst) < 32'(eff));
    assign o_status.n_zero     = (eff == '0);
    assign o_status.cand_any   = |cand;
    assign o_status.hit        = r_on_path[w];
    assign o_status.depth_one  = (r_depth == DW'(1));
    assign o_status.last_start = ((DW'(r_start) + DW'(1)) == eff);
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid  = r_out_valid;
    assign o_has_cycle = r_out_data;

    a_path_in_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on_path & ~r_visited) == '0)
        else $error("path vertex not marked visited");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= N)
        else $error("path stack overflow");

    a_push_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch |-> !r_visited[r_cur])
        else $error("vertex pushed twice");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (32'(r_depth) >= 2))
        else $error("pop below the start vertex");

endmodule

### hdl/directed_graph_cycle_check_unit.sv
// edge load: accepted while idle, row read-modify-write in the edge write state, then ready again
// ignored edge (endpoint out of range): accepted and dropped while idle; check: accepted while
// idle, then a row fetch and a scan per vertex entered and a scan and a stack reload per
// backtrack via the adjacency ram; the result goes into the output register once it is free
// reset (synchronous, active low): empty graph via per-row valid bits, no clearing pass,
// num_vertices back to 16, output empty
module directed_graph_cycle_check_unit import dgcc_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: num_vertices
    input  logic              i_cfg_we,
    input  logic [NUMV_W-1:0] i_cfg_wdata,
    // request stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [3:0] src_vertex, [7:4] dst_vertex
    input  logic              i_s_tuser,   // [0] req_type
    // result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata    // [0] has_cycle, [7:1] zero
);

    t_cmd    cmd;
    t_status status;
    logic    has_cycle;

    // sequencer: idle / edge write / dfs fetch, scan, backtrack / result handoff
    dgcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // adjacency ram, path stack ram, visited and on-path masks, output register
    dgcc_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_req_type  (i_s_tuser),
        .i_src       (i_s_tdata[3:0]),
        .i_dst       (i_s_tdata[7:4]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_has_cycle (has_cycle),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    // ready only while idle; a pending result does not block new requests
    assign o_s_tready = cmd.in_ready;
    assign o_m_tdata  = {7'b0, has_cycle};

endmodule
